// ===== src/xbr_pkg.sv =====
// Package for the XMODEM block receiver: shared constants, types and the CRC step.
// No dependencies.
package xbr_pkg;

   localparam int LongBlockBytes  = 1024;
   localparam int ShortBlockBytes = 128;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_CRC = 8'h43;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_BYTE    = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;
   localparam logic [1:0] CMD_RSVD    = 2'd3;

   localparam logic [1:0] MODE_CSUM = 2'd0;
   localparam logic [1:0] MODE_CRC  = 2'd1;
   localparam logic [1:0] MODE_1K   = 2'd2;

   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // one item queued between front and back
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
   } item_type;

   // one reply group produced by the back end
   typedef struct packed {
      logic [7:0]  first_byte;
      logic        has_cans;
      logic        done_res;
      logic        aborted;
      logic [31:0] total;
   } reply_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== src/xmodem_block_receiver.sv =====
// XMODEM block receiver top level: front queue plus protocol back end.
// The first reply beat leaves through the queue and then the output register.
// Throughput: one item per cycle unless the queue is full or rsp_stall holds a reply;
// a reply of three beats holds the back end until its final beat leaves. Synchronous
// active-high reset: idle phase, mode CRC, retry limit 10; block store contents are undefined.
// Uses xbr_pkg, xbr_front, xbr_back.
module xmodem_block_receiver
   import xbr_pkg::*;
#(
   parameter int LONG_BLOCK_BYTES  = LongBlockBytes,
   parameter int SHORT_BLOCK_BYTES = ShortBlockBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [3:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic        rsp_aborted,
   output logic [31:0] rsp_received_total
);
   logic     q_valid, q_take;
   item_type q_item;

   xbr_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_rx_byte,
      .q_valid, .q_take, .q_item
   );

   xbr_back #(
      .LONG_BLOCK_BYTES(LONG_BLOCK_BYTES), .SHORT_BLOCK_BYTES(SHORT_BLOCK_BYTES)
   ) u_back (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .q_valid, .q_take, .q_item,
      .rsp_valid, .rsp_stall, .rsp_tx_byte, .rsp_last, .rsp_done_res,
      .rsp_aborted, .rsp_received_total
   );
endmodule

// ===== src/xbr_front.sv =====
// Front end: takes items, drops the reserved command, which never has an effect, queues the rest.
// Uses xbr_pkg.
module xbr_front
   import xbr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_rx_byte,
   output logic     q_valid,
   input  logic     q_take,
   output item_type q_item
);
   // two-entry queue
   item_type  mem_ff [2];
   logic      wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   // unknown command 3 never has an effect
   assign push = req_valid && !req_stall && (req_cmd != CMD_RSVD);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = mem_ff[rd_ptr_ff];
   assign pop = q_valid && q_take;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{cmd: req_cmd, rx_byte: req_rx_byte};
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
endmodule

// ===== src/xbr_back.sv =====
// Back end: protocol engine, block store, reply serializer with output register.
// Uses xbr_pkg.
module xbr_back
   import xbr_pkg::*;
#(
   parameter int LONG_BLOCK_BYTES  = LongBlockBytes,
   parameter int SHORT_BLOCK_BYTES = ShortBlockBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [3:0]  csr_data,
   input  logic        q_valid,
   output logic        q_take,
   input  item_type    q_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic        rsp_aborted,
   output logic [31:0] rsp_received_total
);
   localparam int AW = $clog2(LONG_BLOCK_BYTES);
   localparam logic [10:0] LONG_N  = 11'(LONG_BLOCK_BYTES);
   localparam logic [10:0] SHORT_N = 11'(SHORT_BLOCK_BYTES);

   typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_BODY, PH_ENDED} phase_type;

   logic [1:0]  mode_ff;
   logic [3:0]  limit_ff;
   phase_type   phase_ff, phase_in;
   logic [10:0] pos_ff, pos_in;
   logic        long_ff, long_in;
   logic [7:0]  exp_ff, exp_in, gnum_ff, gnum_in, gcmp_ff, gcmp_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  sum_ff, sum_in, ghi_ff, ghi_in;
   logic [1:0]  can_ff, can_in;
   logic [3:0]  retry_ff, retry_in;
   logic [31:0] total_ff, total_in;
   logic [7:0]  store_ff [LONG_BLOCK_BYTES];

   // output stage: reply group and remaining beat count
   reply_type   rep_ff, rep_in;
   logic [1:0]  left_ff, idx_ff;
   logic        have_reply;

   logic        busy, fire;
   logic        status_set, status_ok, status_prev;
   logic        store_we;
   logic [AW-1:0] store_addr;
   logic [10:0] n_bytes, add;
   logic        crc_mode;
   logic [7:0]  prevb;
   logic        num_ok, num_prev, integ_ok;
   logic        ab, dn;
   logic [32:0] sum_total;

   assign busy   = (left_ff != 2'd0);
   // accept next item when output is empty or its final beat leaves now
   assign q_take = !busy || (left_ff == 2'd1 && !rsp_stall);
   assign fire   = q_valid && q_take;

   assign crc_mode = long_ff || mode_ff == MODE_CRC || mode_ff == MODE_1K;
   assign n_bytes  = long_ff ? LONG_N : SHORT_N;
   assign prevb    = exp_ff - 8'd1;
   assign num_ok   = gnum_ff == exp_ff && gcmp_ff == ~exp_ff;
   assign num_prev = gnum_ff == prevb && gcmp_ff == ~prevb;
   assign integ_ok = crc_mode
      ? (ghi_ff == crc_ff[15:8] && q_item.rx_byte == crc_ff[7:0])
      : (sum_ff == q_item.rx_byte);
   assign store_addr = AW'(pos_ff - 11'd2);

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; long_in = long_ff; exp_in = exp_ff;
      gnum_in = gnum_ff; gcmp_in = gcmp_ff; crc_in = crc_ff; sum_in = sum_ff;
      ghi_in = ghi_ff; can_in = can_ff; retry_in = retry_ff; total_in = total_ff;
      status_set = 1'b0; status_ok = 1'b0; status_prev = 1'b0;
      store_we = 1'b0; add = 11'd0; ab = 1'b0; dn = 1'b0;
      rep_in = rep_ff;
      rep_in.has_cans = 1'b0;
      sum_total = '0;
      if (q_item.cmd == CMD_START) begin
         phase_in = PH_HEADER; exp_in = 8'd1; retry_in = '0; can_in = '0;
         total_in = '0; pos_in = '0;
      end else if (q_item.cmd == CMD_BYTE && phase_ff == PH_HEADER) begin
         unique case (q_item.rx_byte)
            CH_SOH: begin
               can_in = '0; phase_in = PH_BODY; long_in = 1'b0; pos_in = '0;
               crc_in = '0; sum_in = '0;
            end
            CH_STX: begin
               can_in = '0;
               if (mode_ff == MODE_1K) begin
                  phase_in = PH_BODY; long_in = 1'b1; pos_in = '0;
                  crc_in = '0; sum_in = '0;
               end else begin
                  status_set = 1'b1;
               end
            end
            CH_EOT: begin
               can_in = '0; status_set = 1'b1; status_ok = 1'b1; dn = 1'b1;
               phase_in = PH_ENDED;
            end
            CH_CAN: begin
               if (can_ff < 2'd3) can_in = can_ff + 2'd1;
               status_set = 1'b1;
               if (can_in >= 2'd2) begin
                  ab = 1'b1; phase_in = PH_ENDED;
               end
            end
            default: status_set = 1'b1;
         endcase
      end else if (q_item.cmd == CMD_BYTE && phase_ff == PH_BODY) begin
         add = n_bytes;
         if (pos_ff == 11'd0) begin
            gnum_in = q_item.rx_byte;
         end else if (pos_ff == 11'd1) begin
            gcmp_in = q_item.rx_byte;
         end else if (pos_ff < n_bytes + 11'd2) begin
            store_we = 1'b1;
            crc_in = crc_step(crc_ff, q_item.rx_byte);
            sum_in = sum_ff + q_item.rx_byte;
         end else if (crc_mode && pos_ff == n_bytes + 11'd2) begin
            ghi_in = q_item.rx_byte;
         end else begin
            status_set = 1'b1;
            status_ok = num_ok && integ_ok;
            status_prev = !num_ok && num_prev;
         end
         if (status_set) phase_in = PH_HEADER;
         else pos_in = pos_ff + 11'd1;
      end else if (q_item.cmd == CMD_TIMEOUT && phase_ff == PH_BODY) begin
         phase_in = PH_HEADER; status_set = 1'b1;
      end

      if (q_item.cmd == CMD_START) begin
         rep_in.first_byte = (mode_ff == MODE_CRC || mode_ff == MODE_1K) ? CH_CRC : CH_NAK;
      end else begin
         rep_in.first_byte = (status_ok || status_prev) ? CH_ACK : CH_NAK;
      end
      if (status_set) begin
         if (status_ok) begin
            exp_in = exp_ff + 8'd1;
            sum_total = {1'b0, total_ff} + {22'd0, add};
            total_in = sum_total[32] ? 32'hFFFF_FFFF : sum_total[31:0];
            retry_in = '0;
         end else begin
            if (retry_ff < 4'd15) retry_in = retry_ff + 4'd1;
            if (retry_in >= limit_ff) begin
               ab = 1'b1; phase_in = PH_ENDED; rep_in.has_cans = 1'b1;
            end
         end
      end
      rep_in.done_res = dn;
      rep_in.aborted  = ab;
      rep_in.total    = total_in;
   end

   assign have_reply = (q_item.cmd == CMD_START) || status_set;

   always_ff @(posedge clock) begin
      if (fire && store_we) store_ff[store_addr] <= q_item.rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CRC; limit_ff <= 4'd10;
         phase_ff <= PH_IDLE; pos_ff <= '0; long_ff <= 1'b0; exp_ff <= 8'd1;
         gnum_ff <= '0; gcmp_ff <= '0; crc_ff <= '0; sum_ff <= '0; ghi_ff <= '0;
         can_ff <= '0; retry_ff <= '0; total_ff <= '0;
         left_ff <= '0; idx_ff <= '0;
      end else begin
         if (csr_write && csr_index == CSR_MODE)  mode_ff  <= csr_data[1:0];
         if (csr_write && csr_index == CSR_LIMIT) limit_ff <= csr_data;
         // a new reply group replaces the final beat leaving at this edge
         if (fire && have_reply) begin
            left_ff <= rep_in.has_cans ? 2'd3 : 2'd1;
            idx_ff  <= '0;
         end else if (busy && !rsp_stall) begin
            left_ff <= left_ff - 2'd1;
            idx_ff  <= idx_ff + 2'd1;
         end
         if (fire) begin
            phase_ff <= phase_in; pos_ff <= pos_in; long_ff <= long_in;
            exp_ff <= exp_in; gnum_ff <= gnum_in; gcmp_ff <= gcmp_in;
            crc_ff <= crc_in; sum_ff <= sum_in; ghi_ff <= ghi_in;
            can_ff <= can_in; retry_ff <= retry_in; total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && have_reply) rep_ff <= rep_in;
   end

   assign rsp_valid          = busy;
   assign rsp_tx_byte        = (idx_ff == 2'd0) ? rep_ff.first_byte : CH_CAN;
   assign rsp_last           = (left_ff == 2'd1);
   assign rsp_done_res       = rep_ff.done_res;
   assign rsp_aborted        = rep_ff.aborted;
   assign rsp_received_total = rep_ff.total;

   a_left: assert property (@(posedge clock) disable iff (reset)
      left_ff != 2'd2 || idx_ff == 2'd1) else $error("beat index out of step");
   a_cans: assert property (@(posedge clock) disable iff (reset)
      busy && idx_ff != 2'd0 |-> rep_ff.aborted) else $error("CAN beat without abort");
   a_done: assert property (@(posedge clock) disable iff (reset)
      busy && rep_ff.done_res |-> left_ff == 2'd1) else $error("EOT reply too long");
endmodule
